// ===== rtl/core/esdt_pkg.sv =====
// ----------------------------------------------------------------------------
// esdt_pkg
// Shared types and constants for the epoch seconds to calendar date unit.
// ----------------------------------------------------------------------------
package esdt_pkg;

    // Width of the shared subtract/compare unit operands.
    localparam int SUB_W = 18;

    // Divide by 86400, 3600 and 60 as a shift by 7, 4 and 2 followed by a
    // reciprocal multiply for the odd factor 675, 225 and 15.
    localparam logic [25:0] DAY_RECIP  = 26'd50903317;  // ceil(2^35 / 675)
    localparam logic [9:0]  DAY_ODD    = 10'd675;
    localparam logic [13:0] HOUR_RECIP = 14'd9321;      // ceil(2^21 / 225)
    localparam logic [7:0]  HOUR_ODD   = 8'd225;
    localparam logic [10:0] MIN_RECIP  = 11'd1093;      // ceil(2^14 / 15)
    localparam logic [3:0]  MIN_ODD    = 4'd15;

    // Calendar starting point and leap-rule counters for that year.
    localparam logic [11:0] FIRST_YEAR  = 12'd1970;
    localparam logic [1:0]  FIRST_MOD4  = 2'd2;
    localparam logic [6:0]  FIRST_MOD100 = 7'd70;
    localparam logic [8:0]  FIRST_MOD400 = 9'd370;
    localparam logic [6:0]  LAST_MOD100 = 7'd99;
    localparam logic [8:0]  LAST_MOD400 = 9'd399;
    localparam logic [8:0]  COMMON_YEAR = 9'd365;
    localparam logic [3:0]  LAST_MONTH  = 4'd11;

    typedef struct packed {
        logic [SUB_W-1:0] minuend;
        logic [SUB_W-1:0] subtrahend;
    } t_sub_op;

    typedef struct packed {
        logic [SUB_W-1:0] diff;
        logic             ge;
    } t_sub_res;

    // Days in a month, zero-based month index.
    function automatic logic [4:0] month_days(input logic [3:0] idx, input logic leap);
        logic [4:0] len;
        case (idx)
            4'd0:    len = 5'd31;
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            4'd11:   len = 5'd31;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/core/esdt_sub_unit.sv =====
// ----------------------------------------------------------------------------
// esdt_sub_unit
// Shared subtract and compare unit: difference and a no-borrow flag.
// ----------------------------------------------------------------------------
module esdt_sub_unit import esdt_pkg::*; (
    input  t_sub_op  i_op,
    output t_sub_res o_res
);

    logic [SUB_W:0] wide_diff;

    assign wide_diff  = {1'b0, i_op.minuend} - {1'b0, i_op.subtrahend};
    assign o_res.diff = wide_diff[SUB_W-1:0];
    assign o_res.ge   = ~wide_diff[SUB_W];

endmodule

// ===== rtl/core/epoch_seconds_to_datetime_unit.sv =====
// ----------------------------------------------------------------------------
// epoch_seconds_to_datetime_unit
// Converts seconds since 1970-01-01 00:00:00 to Gregorian date and time.
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  -------   -------------------------------------   ---------------------------
//  command   i_epoch_seconds                         start high while busy low
//  result    o_year o_month o_day_of_month           o_done high for one cycle
//            o_hour o_minute o_second
//
//  From the accepting edge, states S_DDAY, S_SOD, S_DHOUR, S_SOH, S_DMIN and
//  S_DSEC split off day number, hour, minute and second by reciprocal
//  multiplication; S_YEAR then steps one whole year at a time (up to 136
//  years) and S_MONTH one month at a time (up to 11), and the result is
//  registered. All subtractions share a single subtract/compare unit. Reset is
//  synchronous and returns the sequencer to idle. The receiver cannot stall.
// ----------------------------------------------------------------------------
module epoch_seconds_to_datetime_unit import esdt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic [31:0] i_epoch_seconds,
    output logic        busy,
    output logic        o_done,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day_of_month,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DDAY,
        S_SOD,
        S_DHOUR,
        S_SOH,
        S_DMIN,
        S_DSEC,
        S_YEAR,
        S_MONTH
    } t_state;

    t_state      r_state,  n_state;
    logic [31:0] r_secs,   n_secs;
    logic [16:0] r_rem,    n_rem;
    logic [15:0] r_day,    n_day;
    logic [11:0] r_year,   n_year;
    logic [1:0]  r_mod4,   n_mod4;
    logic [6:0]  r_mod100, n_mod100;
    logic [8:0]  r_mod400, n_mod400;
    logic        r_leap,   n_leap;
    logic [3:0]  r_mon,    n_mon;
    logic        r_done,   n_done;
    logic [3:0]  r_month,  n_month;
    logic [4:0]  r_dom,    n_dom;
    logic [4:0]  r_hour,   n_hour;
    logic [5:0]  r_minute, n_minute;
    logic [5:0]  r_second, n_second;

    t_sub_op     sub_op;
    t_sub_res    sub_res;

    logic [50:0] day_prod;
    logic [26:0] hour_prod;
    logic [20:0] min_prod;
    logic [25:0] day_x675;
    logic [12:0] hour_x225;
    logic [9:0]  min_x15;
    logic [8:0]  year_len;
    logic [4:0]  mon_len;
    logic [1:0]  inc_mod4;
    logic [6:0]  inc_mod100;
    logic [8:0]  inc_mod400;

    esdt_sub_unit u_sub (
        .i_op  (sub_op),
        .o_res (sub_res)
    );

    // Quotients: (seconds >> 7) / 675, (sod >> 4) / 225, (soh >> 2) / 15.
    assign day_prod  = {26'd0, r_secs[31:7]} * {25'd0, DAY_RECIP};
    assign hour_prod = {14'd0, r_rem[16:4]} * {13'd0, HOUR_RECIP};
    assign min_prod  = {11'd0, r_rem[11:2]} * {10'd0, MIN_RECIP};

    // Quotient times odd factor, for the remainder subtraction.
    assign day_x675  = {10'd0, r_day} * {16'd0, DAY_ODD};
    assign hour_x225 = {8'd0, r_hour} * {5'd0, HOUR_ODD};
    assign min_x15   = {4'd0, r_minute} * {6'd0, MIN_ODD};

    assign year_len = COMMON_YEAR + {8'd0, r_leap};
    assign mon_len  = month_days(r_mon, r_leap);

    assign inc_mod4   = r_mod4 + 2'd1;
    assign inc_mod100 = (r_mod100 == LAST_MOD100) ? 7'd0 : r_mod100 + 7'd1;
    assign inc_mod400 = (r_mod400 == LAST_MOD400) ? 9'd0 : r_mod400 + 9'd1;

    // Remainders are below 2^10, so the low 18 bits of each difference hold them.
    always_comb begin
        case (r_state)
            S_SOD:   sub_op = '{minuend: r_secs[24:7], subtrahend: day_x675[17:0]};
            S_SOH:   sub_op = '{minuend: {5'd0, r_rem[16:4]}, subtrahend: {5'd0, hour_x225}};
            S_DSEC:  sub_op = '{minuend: {8'd0, r_rem[11:2]}, subtrahend: {8'd0, min_x15}};
            S_YEAR:  sub_op = '{minuend: {2'd0, r_day}, subtrahend: {9'd0, year_len}};
            S_MONTH: sub_op = '{minuend: {2'd0, r_day}, subtrahend: {13'd0, mon_len}};
            default: sub_op = '0;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_secs   = r_secs;
        n_rem    = r_rem;
        n_day    = r_day;
        n_year   = r_year;
        n_mod4   = r_mod4;
        n_mod100 = r_mod100;
        n_mod400 = r_mod400;
        n_leap   = r_leap;
        n_mon    = r_mon;
        n_done   = 1'b0;
        n_month  = r_month;
        n_dom    = r_dom;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_secs  = i_epoch_seconds;
                    n_state = S_DDAY;
                end
            end
            S_DDAY: begin
                n_day   = day_prod[50:35];
                n_state = S_SOD;
            end
            S_SOD: begin
                // second of day
                n_rem   = {sub_res.diff[9:0], r_secs[6:0]};
                n_state = S_DHOUR;
            end
            S_DHOUR: begin
                n_hour  = hour_prod[25:21];
                n_state = S_SOH;
            end
            S_SOH: begin
                // second of hour
                n_rem   = {5'd0, sub_res.diff[7:0], r_rem[3:0]};
                n_state = S_DMIN;
            end
            S_DMIN: begin
                n_minute = min_prod[19:14];
                n_state  = S_DSEC;
            end
            S_DSEC: begin
                n_second = {sub_res.diff[3:0], r_rem[1:0]};
                n_year   = FIRST_YEAR;
                n_mod4   = FIRST_MOD4;
                n_mod100 = FIRST_MOD100;
                n_mod400 = FIRST_MOD400;
                n_leap   = 1'b0;
                n_state  = S_YEAR;
            end
            S_YEAR: begin
                if (sub_res.ge) begin
                    // drop a whole year and advance the leap-rule counters
                    n_day    = sub_res.diff[15:0];
                    n_year   = r_year + 12'd1;
                    n_mod4   = inc_mod4;
                    n_mod100 = inc_mod100;
                    n_mod400 = inc_mod400;
                    n_leap   = (inc_mod4 == 2'd0) &&
                               ((inc_mod100 != 7'd0) || (inc_mod400 == 9'd0));
                end else begin
                    n_mon   = '0;
                    n_state = S_MONTH;
                end
            end
            S_MONTH: begin
                if (sub_res.ge && (r_mon != LAST_MONTH)) begin
                    n_day = sub_res.diff[15:0];
                    n_mon = r_mon + 4'd1;
                end else begin
                    n_month = r_mon + 4'd1;
                    n_dom   = r_day[4:0] + 5'd1;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_secs   <= n_secs;
        r_rem    <= n_rem;
        r_day    <= n_day;
        r_year   <= n_year;
        r_mod4   <= n_mod4;
        r_mod100 <= n_mod100;
        r_mod400 <= n_mod400;
        r_leap   <= n_leap;
        r_mon    <= n_mon;
        r_month  <= n_month;
        r_dom    <= n_dom;
        r_hour   <= n_hour;
        r_minute <= n_minute;
        r_second <= n_second;
    end

    // The year counter holds the final year once stepping stops.
    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_year         = r_year;
    assign o_month        = r_month;
    assign o_day_of_month = r_dom;
    assign o_hour         = r_hour;
    assign o_minute       = r_minute;
    assign o_second       = r_second;

endmodule

// ===== rtl/core/esdt_checker.sv =====
// ----------------------------------------------------------------------------
// esdt_checker
// Port-level checks for the epoch seconds to calendar date unit.
// ----------------------------------------------------------------------------
module esdt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [11:0] o_year,
    input logic [3:0]  o_month,
    input logic [4:0]  o_day_of_month,
    input logic [4:0]  o_hour,
    input logic [5:0]  o_minute,
    input logic [5:0]  o_second
);

    // An accepted word always starts a conversion.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    // Busy drops exactly when a result word is strobed.
    a_fall_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) && $past(i_rst_n) |-> o_done)
        else $error("busy fell without a result word");

    a_done_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $fell(busy))
        else $error("result word without end of conversion");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_year >= 12'd1970) && (o_year <= 12'd2106) &&
                   (o_month != 4'd0) && (o_month <= 4'd12) &&
                   (o_day_of_month != 5'd0))
        else $error("date out of range");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_hour < 5'd24) && (o_minute < 6'd60) && (o_second < 6'd60))
        else $error("time of day out of range");

endmodule

bind epoch_seconds_to_datetime_unit esdt_checker u_esdt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_done         (o_done),
    .o_year         (o_year),
    .o_month        (o_month),
    .o_day_of_month (o_day_of_month),
    .o_hour         (o_hour),
    .o_minute       (o_minute),
    .o_second       (o_second)
);
